[sv/osdtt_pkg.sv]
// shared types and constants of the one-shot delay timer table
package osdtt_pkg;

  localparam int unsigned TimeW      = 48;
  localparam int unsigned DelayW     = 32;
  localparam int unsigned TagInW     = 16;
  localparam int unsigned SlotOutW   = 4;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned FireCntW   = 5;

  typedef enum logic [2:0] {
    MODE_SCHEDULE = 3'd0,
    MODE_POLL     = 3'd1,
    MODE_PAUSE    = 3'd2,
    MODE_RESUME   = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_FIRED     = 2'd0,
    KIND_SCHEDULED = 2'd1,
    KIND_FULL      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // what the head unit decided about the slot passing it
  typedef struct packed {
    logic take;
    logic append;
    logic fire;
  } head_ctl_t;

endpackage

[sv/one_shot_delay_timer_table_top.sv]
// one-shot timer table: ring of slot cells rotating past a single head unit
// schedule, poll and a resume while paused rotate the ring once, then pass
//   through a done state before the next beat is accepted
// pause, clear, ignored modes and polls while paused leave the ring still
// poll results leave one per cycle as found, stalls at the output hold the ring
// reset empties the table (no live slots) and clears the paused state
module one_shot_delay_timer_table_top #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned TAG_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // now_us[47:0], delay_us[79:48], tag[95:80]
  input  logic [2:0]   s_axis_tuser,   // mode[2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // slot_index[3:0], fired_tag[19:4], zero[23:20]
  output logic [1:0]   m_axis_tuser,   // result_kind[1:0]
  output logic         m_axis_tlast
);
  import osdtt_pkg::*;

  localparam int unsigned IdxW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned UsedW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned TagW  = (TAG_BITS < TagInW) ? TAG_BITS : TagInW;

  // input fields
  logic [TimeW-1:0]  in_now;
  logic [DelayW-1:0] in_delay;
  logic [TagW-1:0]   in_tag;
  mode_e             in_mode;
  logic              in_acc;

  assign in_now   = s_axis_tdata[47:0];
  assign in_delay = s_axis_tdata[79:48];
  assign in_tag   = TagW'(s_axis_tdata[95:80]);
  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // control and item registers
  state_e               state_q, state_d;
  logic [IdxW-1:0]      cnt_q, cnt_d;
  logic [UsedW-1:0]     used_q, used_d;
  logic                 paused_q, paused_d;
  logic [TimeW-1:0]     pause_start_q, pause_start_d;
  mode_e                mode_q, mode_d;
  logic [TimeW-1:0]     op_time_q, op_time_d;
  logic [TagW-1:0]      tag_q, tag_d;
  logic                 found_q, found_d;
  logic [IdxW-1:0]      found_slot_q, found_slot_d;
  logic [FireCntW-1:0]  fire_cnt_q, fire_cnt_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]      pend_slot_q, pend_slot_d;
  logic [TagW-1:0]      pend_tag_q, pend_tag_d;

  // output register
  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [IdxW-1:0]      out_slot_q;
  logic [TagW-1:0]      out_tag_q;
  logic                 out_last_q;
  logic                 out_free;

  logic                 push;
  kind_e                push_kind;
  logic [IdxW-1:0]      push_slot;
  logic [TagW-1:0]      push_tag;
  logic                 push_last;
  logic                 shift;

  // ring
  logic [TimeW-1:0] cell_dl  [NUM_SLOTS];
  logic             cell_exp [NUM_SLOTS];
  logic [TagW-1:0]  cell_tag [NUM_SLOTS];
  logic [TimeW-1:0] head_dl;
  logic             head_exp;
  logic [TagW-1:0]  head_tag;
  head_ctl_t        ctl;

  osdtt_head #(
    .IdxW  (IdxW),
    .UsedW (UsedW),
    .TagW  (TagW)
  ) u_head (
    .mode_i     (mode_q),
    .cnt_i      (cnt_q),
    .used_i     (used_q),
    .op_time_i  (op_time_q),
    .tag_i      (tag_q),
    .found_i    (found_q),
    .fire_cnt_i (fire_cnt_q),
    .dl_i       (cell_dl[0]),
    .exp_i      (cell_exp[0]),
    .slot_tag_i (cell_tag[0]),
    .dl_o       (head_dl),
    .exp_o      (head_exp),
    .tag_o      (head_tag),
    .ctl_o      (ctl)
  );

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    if (k == NUM_SLOTS - 1) begin : g_tail
      osdtt_cell #(.TagW(TagW)) u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .dl_i    (head_dl),
        .exp_i   (head_exp),
        .tag_i   (head_tag),
        .dl_o    (cell_dl[k]),
        .exp_o   (cell_exp[k]),
        .tag_o   (cell_tag[k])
      );
    end else begin : g_mid
      osdtt_cell #(.TagW(TagW)) u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .dl_i    (cell_dl[k+1]),
        .exp_i   (cell_exp[k+1]),
        .tag_i   (cell_tag[k+1]),
        .dl_o    (cell_dl[k]),
        .exp_o   (cell_exp[k]),
        .tag_o   (cell_tag[k])
      );
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    used_d        = used_q;
    paused_d      = paused_q;
    pause_start_d = pause_start_q;
    mode_d        = mode_q;
    op_time_d     = op_time_q;
    tag_d         = tag_q;
    found_d       = found_q;
    found_slot_d  = found_slot_q;
    fire_cnt_d    = fire_cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_slot_d   = pend_slot_q;
    pend_tag_d    = pend_tag_q;
    push          = 1'b0;
    push_kind     = KIND_FIRED;
    push_slot     = pend_slot_q;
    push_tag      = pend_tag_q;
    push_last     = 1'b0;
    shift         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_d       = in_mode;
          cnt_d        = '0;
          found_d      = 1'b0;
          fire_cnt_d   = '0;
          pend_valid_d = 1'b0;
          case (in_mode)
            MODE_SCHEDULE: begin
              op_time_d = in_now + TimeW'(in_delay);
              tag_d     = in_tag;
              state_d   = ST_SCAN;
            end
            MODE_POLL: begin
              if (!paused_q) begin
                op_time_d = in_now;
                state_d   = ST_SCAN;
              end
            end
            MODE_PAUSE: begin
              paused_d      = 1'b1;
              pause_start_d = in_now;
            end
            MODE_RESUME: begin
              if (paused_q) begin
                paused_d  = 1'b0;
                // time going back gives an empty span
                op_time_d = (in_now >= pause_start_q) ? in_now - pause_start_q : '0;
                state_d   = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              used_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // a new firing releases the held one, which is not the last
        if (ctl.fire && pend_valid_q) begin
          push = out_free;
        end
        shift = !(ctl.fire && pend_valid_q && !out_free);
        if (shift) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == IdxW'(NUM_SLOTS - 1)) begin
            state_d = ST_DONE;
          end
          if (ctl.take) begin
            found_d      = 1'b1;
            found_slot_d = cnt_q;
            if (ctl.append) begin
              used_d = used_q + 1'b1;
            end
          end
          if (ctl.fire) begin
            pend_valid_d = 1'b1;
            pend_slot_d  = cnt_q;
            pend_tag_d   = cell_tag[0];
            fire_cnt_d   = fire_cnt_q + 1'b1;
          end
        end
      end
      ST_DONE: begin
        case (mode_q)
          MODE_SCHEDULE: begin
            push_kind = found_q ? KIND_SCHEDULED : KIND_FULL;
            push_slot = found_q ? found_slot_q : '0;
            push_tag  = found_q ? tag_q : '0;
            push_last = 1'b1;
            if (out_free) begin
              push    = 1'b1;
              state_d = ST_IDLE;
            end
          end
          MODE_POLL: begin
            push_last = 1'b1;
            if (!pend_valid_q) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              push         = 1'b1;
              pend_valid_d = 1'b0;
              state_d      = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      used_q        <= '0;
      paused_q      <= 1'b0;
      pause_start_q <= '0;
      found_q       <= 1'b0;
      fire_cnt_q    <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      used_q        <= used_d;
      paused_q      <= paused_d;
      pause_start_q <= pause_start_d;
      found_q       <= found_d;
      fire_cnt_q    <= fire_cnt_d;
      pend_valid_q  <= pend_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    op_time_q    <= op_time_d;
    tag_q        <= tag_d;
    found_slot_q <= found_slot_d;
    pend_slot_q  <= pend_slot_d;
    pend_tag_q   <= pend_tag_d;
    if (push) begin
      out_kind_q <= push_kind;
      out_slot_q <= push_slot;
      out_tag_q  <= push_tag;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, TagInW'(out_tag_q), SlotOutW'(out_slot_q)};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[sv/osdtt_cell.sv]
// one timer slot of the rotating ring, loads from its neighbor on every shift
module osdtt_cell #(
  parameter int unsigned TagW = 16
) (
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic [osdtt_pkg::TimeW-1:0] dl_i,
  input  logic                       exp_i,
  input  logic [TagW-1:0]            tag_i,
  output logic [osdtt_pkg::TimeW-1:0] dl_o,
  output logic                       exp_o,
  output logic [TagW-1:0]            tag_o
);
  import osdtt_pkg::*;

  logic [TimeW-1:0] dl_q;
  logic             exp_q;
  logic [TagW-1:0]  tag_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      dl_q  <= dl_i;
      exp_q <= exp_i;
      tag_q <= tag_i;
    end
  end

  assign dl_o  = dl_q;
  assign exp_o = exp_q;
  assign tag_o = tag_q;

endmodule

[sv/osdtt_head.sv]
// head unit: examines and updates the slot leaving the front of the ring
module osdtt_head #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned UsedW = 5,
  parameter int unsigned TagW  = 16
) (
  input  osdtt_pkg::mode_e                mode_i,
  input  logic [IdxW-1:0]                 cnt_i,
  input  logic [UsedW-1:0]                used_i,
  input  logic [osdtt_pkg::TimeW-1:0]     op_time_i,
  input  logic [TagW-1:0]                 tag_i,
  input  logic                            found_i,
  input  logic [osdtt_pkg::FireCntW-1:0]  fire_cnt_i,
  input  logic [osdtt_pkg::TimeW-1:0]     dl_i,
  input  logic                            exp_i,
  input  logic [TagW-1:0]                 slot_tag_i,
  output logic [osdtt_pkg::TimeW-1:0]     dl_o,
  output logic                            exp_o,
  output logic [TagW-1:0]                 tag_o,
  output osdtt_pkg::head_ctl_t            ctl_o
);
  import osdtt_pkg::*;

  logic live;
  logic at_end;

  assign live   = UsedW'(cnt_i) < used_i;
  assign at_end = UsedW'(cnt_i) == used_i;

  always_comb begin
    ctl_o = '0;
    dl_o  = dl_i;
    exp_o = exp_i;
    tag_o = slot_tag_i;
    case (mode_i)
      MODE_SCHEDULE: begin
        // first expired live slot wins, else the first slot past the live range
        if (!found_i && ((live && exp_i) || at_end)) begin
          ctl_o.take   = 1'b1;
          ctl_o.append = at_end;
          dl_o         = op_time_i;
          exp_o        = 1'b0;
          tag_o        = tag_i;
        end
      end
      MODE_POLL: begin
        if (live && !exp_i && (op_time_i >= dl_i) &&
            (fire_cnt_i < FireCntW'(MaxResults))) begin
          ctl_o.fire = 1'b1;
          exp_o      = 1'b1;
        end
      end
      MODE_RESUME: begin
        dl_o = dl_i + op_time_i;
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/osdtt_checker.sv]
// port-level checks of the timer table, bound to the top level
module osdtt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import osdtt_pkg::*;

  // a stalled result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // no result kind beyond table full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("bad result kind");

  // full reports carry no slot or tag and end the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_FULL) |-> (m_axis_tdata == 24'd0) && m_axis_tlast)
    else $error("table full beat malformed");

  // schedule always walks the ring, so the input closes right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_SCHEDULE) |=> !s_axis_tready)
    else $error("input open during schedule scan");

  // scheduled reports always end the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_SCHEDULED) |-> m_axis_tlast)
    else $error("scheduled beat without last");

endmodule

bind one_shot_delay_timer_table_top osdtt_checker u_osdtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/tb_one_shot_delay_timer_table_top.sv]
// self-checking testbench of the one-shot delay timer table: directed rows, then random beats
module tb_one_shot_delay_timer_table_top;
  import osdtt_pkg::*;

  localparam int unsigned NumSlots    = 16;
  localparam int unsigned RandomItems = 160;
  localparam int unsigned QuietFrom   = 60;
  localparam int unsigned QuietTo     = 120;
  localparam int unsigned DrainCycles = 2 * NumSlots + 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam logic [2:0]  ModeSpareLo = 3'd5;
  localparam logic [2:0]  ModeSpareMid = 3'd6;
  localparam logic [2:0]  ModeSpareHi = 3'd7;
  localparam logic [47:0] TimeMax     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] DelayMax    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    BY_MODEL,
    NO_RESULT,
    ONE_RESULT
  } row_check_e;

  typedef struct {
    kind_e       kind;
    logic [3:0]  slot;
    logic [15:0] tag;
    logic        last;
  } timer_result_t;

  typedef struct {
    logic [2:0]    mode;
    logic [47:0]   now;
    logic [31:0]   delay;
    logic [15:0]   tag;
    int unsigned   reps;
    row_check_e    chk;
    timer_result_t typed;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // now_us[47:0], delay_us[79:48], tag[95:80]
  logic [2:0]   s_axis_tuser = '0;   // mode[2:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;        // slot_index[3:0], fired_tag[19:4], zero[23:20]
  logic [1:0]   m_axis_tuser;        // result_kind[1:0]
  logic         m_axis_tlast;

  // timer table mirror
  logic [47:0]   slot_deadline [NumSlots];
  logic          slot_expired  [NumSlots];
  logic [15:0]   slot_tag      [NumSlots];
  int unsigned   live_count = 0;
  logic          is_paused = 1'b0;
  logic [47:0]   paused_at = '0;

  timer_result_t awaited_results [$];
  stim_row_t     stim_rows [$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            quiet = 1'b0;

  one_shot_delay_timer_table_top #(
    .NUM_SLOTS (NumSlots),
    .TAG_BITS  (16)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic push_result(input kind_e kind, input logic [3:0] slot,
                             input logic [15:0] tag, input logic last);
    timer_result_t r;
    r.kind = kind;
    r.slot = slot;
    r.tag  = tag;
    r.last = last;
    awaited_results = {awaited_results, r};
  endtask

  // advance the mirror by one input beat and queue what it fires or assigns
  task automatic timer_table_step(input logic [2:0] mode, input logic [47:0] now,
                                  input logic [31:0] delay, input logic [15:0] tag);
    int unsigned pick;
    int unsigned fired;
    logic [47:0] span;
    pick  = live_count;
    fired = 0;
    if (mode == MODE_SCHEDULE) begin
      for (int unsigned i = 0; i < live_count; i++) begin
        if (slot_expired[i]) begin
          pick = i;
          break;
        end
      end
      if (pick >= NumSlots) begin
        push_result(KIND_FULL, '0, '0, 1'b1);
      end else begin
        if (pick == live_count) live_count++;
        slot_expired[pick]  = 1'b0;
        slot_deadline[pick] = now + {16'd0, delay};
        slot_tag[pick]      = tag;
        push_result(KIND_SCHEDULED, pick[3:0], tag, 1'b1);
      end
    end else if (mode == MODE_POLL) begin
      if (!is_paused) begin
        for (int unsigned i = 0; i < live_count && fired < MaxResults; i++) begin
          if (!slot_expired[i] && now >= slot_deadline[i]) begin
            slot_expired[i] = 1'b1;
            push_result(KIND_FIRED, i[3:0], slot_tag[i], 1'b0);
            fired++;
          end
        end
        if (fired > 0) awaited_results[awaited_results.size() - 1].last = 1'b1;
      end
    end else if (mode == MODE_PAUSE) begin
      is_paused = 1'b1;
      paused_at = now;
    end else if (mode == MODE_RESUME) begin
      if (is_paused) begin
        is_paused = 1'b0;
        span = (now >= paused_at) ? now - paused_at : '0;
        for (int unsigned i = 0; i < live_count; i++) slot_deadline[i] += span;
      end
    end else if (mode == MODE_CLEAR) begin
      live_count = 0;
    end
  endtask

  // present one beat, wait for the handshake, then update the mirror
  task automatic send_item(input logic [2:0] mode, input logic [47:0] now,
                           input logic [31:0] delay, input logic [15:0] tag,
                           input row_check_e chk, input timer_result_t typed);
    int unsigned depth;
    while (!quiet && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, delay, now};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    depth = awaited_results.size();
    timer_table_step(mode, now, delay, tag);
    if (chk != BY_MODEL) begin
      // rows with a hand-written answer replace what the mirror queued
      while (awaited_results.size() > depth) void'(awaited_results.pop_back());
      if (chk == ONE_RESULT) awaited_results = {awaited_results, typed};
    end
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic [2:0] mode, input logic [47:0] now,
                         input logic [31:0] delay, input logic [15:0] tag,
                         input int unsigned reps, input row_check_e chk,
                         input kind_e kind, input logic [3:0] slot,
                         input logic [15:0] rtag);
    stim_row_t row;
    row.mode       = mode;
    row.now        = now;
    row.delay      = delay;
    row.tag        = tag;
    row.reps       = reps;
    row.chk        = chk;
    row.typed.kind = kind;
    row.typed.slot = slot;
    row.typed.tag  = rtag;
    row.typed.last = 1'b1;
    stim_rows = {stim_rows, row};
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk_i) begin
    timer_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d slot %0d tag %h",
                                  m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]));
      end else begin
        exp_r = awaited_results.pop_front();
        if (m_axis_tuser !== exp_r.kind)
          report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, exp_r.kind));
        if (m_axis_tdata[3:0] !== exp_r.slot)
          report_mismatch($sformatf("slot %0d, want %0d", m_axis_tdata[3:0], exp_r.slot));
        if (m_axis_tdata[19:4] !== exp_r.tag)
          report_mismatch($sformatf("tag %h, want %h", m_axis_tdata[19:4], exp_r.tag));
        if (m_axis_tlast !== exp_r.last)
          report_mismatch($sformatf("last %b, want %b", m_axis_tlast, exp_r.last));
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("one_shot_delay_timer_table_top test failed");
    $finish;
  end

  initial begin
    stim_row_t     row;
    timer_result_t none;
    logic [2:0]    mode;
    logic [47:0]   now;
    logic [31:0]   delay;
    logic [15:0]   tag;
    logic [63:0]   rnd64;
    logic [47:0]   clock_us;
    int unsigned   n_sent;
    int unsigned   r;

    none     = '{KIND_FIRED, 4'd0, 16'd0, 1'b0};
    clock_us = 48'd10000;
    n_sent   = 0;

    add_row(MODE_POLL,     48'd0,      32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_SCHEDULE, 48'd0,      32'd0,     16'h0000, 1,  ONE_RESULT, KIND_SCHEDULED,
            4'd0, 16'h0000);
    // deadline wraps past the top of the time range
    add_row(MODE_SCHEDULE, TimeMax,    DelayMax,  16'hFFFF, 1,  ONE_RESULT, KIND_SCHEDULED,
            4'd1, 16'hFFFF);
    add_row(MODE_POLL,     48'd0,      32'd0,     16'h0000, 1,  BY_MODEL,   KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_SCHEDULE, 48'd100,    32'd50,    16'h1234, 1,  ONE_RESULT, KIND_SCHEDULED,
            4'd0, 16'h1234);
    add_row(MODE_PAUSE,    48'd1000,   32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_POLL,     48'h8000_0000_0000, 32'd0, 16'h0000, 1, NO_RESULT, KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_PAUSE,    48'd2000,   32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_SCHEDULE, 48'd2000,   32'd10,    16'h55AA, 1,  ONE_RESULT, KIND_SCHEDULED,
            4'd2, 16'h55AA);
    // time going back gives a zero paused span
    add_row(MODE_RESUME,   48'd1500,   32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_RESUME,   48'd5000,   32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_PAUSE,    48'd3000,   32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_RESUME,   48'd1003000, 32'd0,    16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_POLL,     TimeMax,    32'd0,     16'h0000, 1,  BY_MODEL,   KIND_FIRED,
            4'd0, 16'd0);
    add_row(ModeSpareLo,   48'h1234_5678_9ABC, 32'hDEAD_BEEF, 16'hC0DE, 1, NO_RESULT,
            KIND_FIRED, 4'd0, 16'd0);
    add_row(ModeSpareMid,  48'd0,      32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(ModeSpareHi,   TimeMax,    DelayMax,  16'hFFFF, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_CLEAR,    48'd0,      32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    // fill every slot, then one more schedule finds the table full
    add_row(MODE_SCHEDULE, 48'h5000,   32'hFFFF_0000, 16'hA000, NumSlots, BY_MODEL,
            KIND_FIRED, 4'd0, 16'd0);
    add_row(MODE_SCHEDULE, 48'd0,      32'd0,     16'hBEEF, 1,  ONE_RESULT, KIND_FULL,
            4'd0, 16'h0000);
    // a paused span that pushes every deadline past the wrap
    add_row(MODE_PAUSE,    48'd0,      32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_RESUME,   TimeMax,    32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_POLL,     TimeMax,    32'd0,     16'h0000, 1,  BY_MODEL,   KIND_FIRED,
            4'd0, 16'd0);
    add_row(MODE_SCHEDULE, 48'd7,      32'd3,     16'h0F0F, 1,  ONE_RESULT, KIND_SCHEDULED,
            4'd0, 16'h0F0F);
    add_row(MODE_CLEAR,    48'd0,      32'd0,     16'h0000, 1,  NO_RESULT,  KIND_FIRED,
            4'd0, 16'd0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      for (int unsigned k = 0; k < row.reps; k++) begin
        send_item(row.mode, row.now + k, row.delay, row.tag + k[15:0], row.chk, row.typed);
      end
    end

    while (n_sent < RandomItems) begin
      quiet = (n_sent >= QuietFrom && n_sent < QuietTo);
      r = $urandom_range(0, 99);
      if (r < 40)      mode = MODE_SCHEDULE;
      else if (r < 72) mode = MODE_POLL;
      else if (r < 82) mode = MODE_PAUSE;
      else if (r < 92) mode = MODE_RESUME;
      else if (r < 96) mode = MODE_CLEAR;
      else             mode = 3'($urandom_range(ModeSpareLo, ModeSpareHi));

      r = $urandom_range(0, 99);
      if (r < 4) begin
        rnd64 = {$urandom(), $urandom()};
        now = rnd64[47:0];
      end else if (r < 9) begin
        now = clock_us - $urandom_range(0, 500);
      end else begin
        clock_us += $urandom_range(0, 1500);
        now = clock_us;
      end
      delay = ($urandom_range(0, 99) < 10) ? $urandom() : $urandom_range(0, 4000);
      tag   = 16'($urandom());

      send_item(mode, now, delay, tag, BY_MODEL, none);
      if (mode <= MODE_CLEAR) n_sent++;
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("one_shot_delay_timer_table_top test passed");
    end else begin
      $display("one_shot_delay_timer_table_top test failed");
    end
    $finish;
  end

endmodule
